// ===== rtl/sorted_insert_table_top_assert.svh =====
// ----------------------------------------------------------------------------
// sorted_insert_table_top_assert.svh
// Assertion macros for the sorted insert table.
// ----------------------------------------------------------------------------
`ifndef SORTED_INSERT_TABLE_TOP_ASSERT_SVH
`define SORTED_INSERT_TABLE_TOP_ASSERT_SVH

// same-cycle implication
`define SIT_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SIT_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/sit_pkg.sv =====
// ----------------------------------------------------------------------------
// sit_pkg
// Types and constants shared by the sorted insert table modules.
// ----------------------------------------------------------------------------
package sit_pkg;

	localparam int CAPACITY      = 16;
	localparam int CNT_W         = $clog2(CAPACITY + 1);
	localparam int WORD_W        = 32;
	localparam int INDEX_FIELD_W = 4;
	localparam int COUNT_FIELD_W = 5;

	localparam logic signed [WORD_W-1:0] EMPTY_MARK = -32'sd1;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_READ   = 1'b1;

	typedef struct packed {
		logic                      op;
		logic signed [WORD_W-1:0]  value;
		logic [INDEX_FIELD_W-1:0]  index;
	} req_t;

	typedef struct packed {
		logic                      accepted;
		logic signed [WORD_W-1:0]  read_value;
		logic                      read_valid;
		logic [COUNT_FIELD_W-1:0]  entry_count;
		logic signed [WORD_W-1:0]  smallest;
		logic signed [WORD_W-1:0]  largest;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

endpackage

// ===== rtl/sit_ctrl.sv =====
// ----------------------------------------------------------------------------
// sit_ctrl
// Controller: accepts one request, runs it through the datapath and holds
// the response until it is taken.
// ----------------------------------------------------------------------------
module sit_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output sit_pkg::cmd_t cmd
);
	import sit_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_nxt = ST_RESP;
			end
			ST_RESP: begin
				if (!rsp_stall) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_stall = 1'b1;
		rsp_valid = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				cmd.load  = req_valid;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			ST_RESP: begin
				rsp_valid = 1'b1;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

endmodule

// ===== rtl/sit_dp.sv =====
// ----------------------------------------------------------------------------
// sit_dp
// Datapath: a row of sorted cells that all compare against the new value
// and shift up in parallel, plus the request and response registers.
// ----------------------------------------------------------------------------
module sit_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  sit_pkg::cmd_t cmd,
	input  sit_pkg::req_t req,
	output sit_pkg::rsp_t rsp
);
	import sit_pkg::*;

	req_t                    req_q;
	rsp_t                    rsp_q;
	logic signed [WORD_W-1:0] cells_q [CAPACITY];
	logic signed [WORD_W-1:0] cells_nxt [CAPACITY];
	logic signed [WORD_W-1:0] shifted [CAPACITY];
	logic signed [WORD_W-1:0] largest_q;
	logic signed [WORD_W-1:0] largest_nxt;
	logic signed [WORD_W-1:0] rd_val;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_after;
	logic [CAPACITY-1:0]      ge;
	logic [CAPACITY-1:0]      take;
	logic [CAPACITY-1:0]      first;
	logic                     full;
	logic                     do_ins;
	logic                     rd_ok;
	rsp_t                     rsp_nxt;

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			ge[i]   = (CNT_W'(i) < count_q) && ($signed(cells_q[i]) >= $signed(req_q.value));
			take[i] = ge[i] || (CNT_W'(i) == count_q);
		end
		first[0]   = take[0];
		shifted[0] = req_q.value;
		for (int i = 1; i < CAPACITY; i++) begin
			first[i]   = take[i] && !take[i-1];
			shifted[i] = cells_q[i-1];
		end
		for (int i = 0; i < CAPACITY; i++) begin
			if (first[i]) begin
				cells_nxt[i] = req_q.value;
			end else if (take[i]) begin
				cells_nxt[i] = shifted[i];
			end else begin
				cells_nxt[i] = cells_q[i];
			end
		end
	end

	assign full        = (count_q == CNT_W'(CAPACITY));
	assign do_ins      = cmd.exec && (req_q.op == OP_INSERT) && !full;
	assign largest_nxt = (|ge) ? largest_q : req_q.value;
	assign count_after = do_ins ? count_q + CNT_W'(1) : count_q;

	always_comb begin
		rd_val = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (int'(req_q.index) == i) begin
				rd_val = cells_q[i];
			end
		end
	end

	assign rd_ok = (req_q.op == OP_READ) && (int'(req_q.index) < int'(count_q));

	always_comb begin
		rsp_nxt.accepted    = do_ins;
		rsp_nxt.read_valid  = rd_ok;
		rsp_nxt.read_value  = rd_ok ? rd_val : '0;
		rsp_nxt.entry_count = COUNT_FIELD_W'(count_after);
		if (count_after == '0) begin
			rsp_nxt.smallest = EMPTY_MARK;
			rsp_nxt.largest  = EMPTY_MARK;
		end else if (do_ins) begin
			rsp_nxt.smallest = cells_nxt[0];
			rsp_nxt.largest  = largest_nxt;
		end else begin
			rsp_nxt.smallest = cells_q[0];
			rsp_nxt.largest  = largest_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_ins) begin
			count_q <= count_after;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (cmd.exec) begin
			rsp_q <= rsp_nxt;
		end
		if (do_ins) begin
			largest_q <= largest_nxt;
			for (int i = 0; i < CAPACITY; i++) begin
				cells_q[i] <= cells_nxt[i];
			end
		end
	end

	assign rsp = rsp_q;

endmodule

// ===== rtl/sorted_insert_table_top.sv =====
// ----------------------------------------------------------------------------
// sorted_insert_table_top
// Bounded table of signed 32-bit values kept in ascending order.
// ----------------------------------------------------------------------------
// Each request either inserts a value in front of the first stored entry
// that is greater than or equal to it, or reads the entry at an index; a
// full table drops inserts with accepted low. Every response carries the
// count and the smallest and largest entries (-1 when empty). One request
// is in flight at a time. An accepted request is loaded into the request
// register and the execute state runs a parallel compare-and-shift over
// all cells into the response register; the response is then valid in
// the response state. The next request can be accepted the cycle after
// the response is taken.
module sorted_insert_table_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  sit_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output sit_pkg::rsp_t rsp
);
	import sit_pkg::*;

	cmd_t cmd;

	sit_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	sit_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

	`include "sorted_insert_table_top_assert.svh"

	`SIT_ASSERT_NXT(a_one_in_flight, clk, arst_n, req_valid && !req_stall, req_stall, "request accepted while busy")
	`SIT_ASSERT_NXT(a_exec_to_rsp, clk, arst_n, cmd.exec, rsp_valid, "no response after execute")
	`SIT_ASSERT_IMP(a_min_le_max, clk, arst_n, rsp_valid && (rsp.entry_count != '0), $signed(rsp.smallest) <= $signed(rsp.largest), "smallest above largest")
	`SIT_ASSERT_IMP(a_ins_no_read, clk, arst_n, rsp_valid && rsp.accepted, !rsp.read_valid, "insert flagged as read")

endmodule

// ===== dv/sorted_insert_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_insert_table_checker
// Response checker for the sorted insert table.
// ----------------------------------------------------------------------------
// Watches both channels. Every accepted request is applied to a local copy
// of the sorted table, and the response it should give is queued. Every
// accepted response is compared field by field with the oldest queued one.
// Mismatches, responses with nothing queued, and the queue depth are handed
// to the testbench top.
module sorted_insert_table_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_stall,
	input  sit_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  sit_pkg::rsp_t rsp,
	output int            fail_count,
	output int            pending
);
	import sit_pkg::*;

	logic signed [WORD_W-1:0] sorted_vals [CAPACITY];
	int                       fill;
	rsp_t                     expected_rsp_q [$];

	task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
			input logic [WORD_W-1:0] want);
		$display("%0t: response mismatch on %s: got %0h, expected %0h",
			$realtime, what, got, want);
		fail_count++;
	endtask

	// Applies one request to the local table and returns the response it gives.
	function automatic rsp_t apply_request(input req_t r);
		rsp_t o;
		int   pos;
		int   i;
		o = '0;
		if (r.op == OP_INSERT) begin
			if (fill < CAPACITY) begin
				pos = fill;
				// first entry >= value; equal entries move up behind the new one
				for (i = fill - 1; i >= 0; i--)
					if ($signed(sorted_vals[i]) >= $signed(r.value))
						pos = i;
				for (i = fill; i > pos; i--)
					sorted_vals[i] = sorted_vals[i-1];
				sorted_vals[pos] = r.value;
				fill++;
				o.accepted = 1'b1;
			end
		end else if (int'(r.index) < fill) begin
			o.read_valid = 1'b1;
			o.read_value = sorted_vals[r.index];
		end
		o.entry_count = fill[COUNT_FIELD_W-1:0];
		if (fill == 0) begin
			o.smallest = EMPTY_MARK;
			o.largest  = EMPTY_MARK;
		end else begin
			o.smallest = sorted_vals[0];
			o.largest  = sorted_vals[fill-1];
		end
		return o;
	endfunction

	task automatic compare_response(input rsp_t got, input rsp_t want);
		if (got.accepted !== want.accepted)
			report_mismatch("accepted", WORD_W'(got.accepted), WORD_W'(want.accepted));
		if (got.read_value !== want.read_value)
			report_mismatch("read_value", got.read_value, want.read_value);
		if (got.read_valid !== want.read_valid)
			report_mismatch("read_valid", WORD_W'(got.read_valid),
				WORD_W'(want.read_valid));
		if (got.entry_count !== want.entry_count)
			report_mismatch("entry_count", WORD_W'(got.entry_count),
				WORD_W'(want.entry_count));
		if (got.smallest !== want.smallest)
			report_mismatch("smallest", got.smallest, want.smallest);
		if (got.largest !== want.largest)
			report_mismatch("largest", got.largest, want.largest);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				expected_rsp_q.push_back(apply_request(req));
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp_q.size() == 0)
					report_mismatch("unexpected response", WORD_W'(rsp.entry_count), '0);
				else
					compare_response(rsp, expected_rsp_q.pop_front());
			end
			pending = expected_rsp_q.size();
		end
	end

endmodule

// ===== dv/sorted_insert_table_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_insert_table_top_tb
// Testbench for the sorted insert table.
// ----------------------------------------------------------------------------
// Drives a directed run over the empty table, extreme and equal values and
// reads past the count, then a random mix of inserts and reads that fills
// the table and keeps hitting the full-table drop. Both sides idle at
// random, with a quiet stretch, and the response side holds off once for a
// long stretch so that request stall backs up. Checking is done by
// sorted_insert_table_checker; this top makes stimulus and gives the verdict.
module sorted_insert_table_top_tb;
	import sit_pkg::*;

	localparam int RANDOM_REQS   = 636;
	localparam int IDLE_PCT      = 29;
	localparam int QUIET_FIRST   = 400;
	localparam int QUIET_LAST    = 520;
	localparam int HOLD_AT       = 250;
	localparam int HOLD_CYCLES   = 60;
	localparam int DRAIN_CYCLES  = 12;
	localparam int WATCHDOG_LIMIT = 1000;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int fail_count;
	int pending;
	int sent_count = 0;
	int idle_cycles = 0;

	always #6 clk = ~clk;

	sorted_insert_table_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	sorted_insert_table_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	function automatic bit in_quiet_stretch();
		return sent_count >= QUIET_FIRST && sent_count < QUIET_LAST;
	endfunction

	function automatic logic signed [WORD_W-1:0] pick_value();
		case ($urandom_range(0, 5))
			0:       return 32'sh7fff_ffff;
			1:       return 32'sh8000_0000;
			2:       return $signed($urandom_range(0, 8)) - 4;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_request(input logic op, input logic signed [WORD_W-1:0] value,
			input logic [INDEX_FIELD_W-1:0] index);
		req_t r;
		r.op    = op;
		r.value = value;
		r.index = index;
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		sent_count++;
		if (!in_quiet_stretch() && $urandom_range(0, 99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// response side: random stall, plus one long hold-off
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (!hold_done && sent_count >= HOLD_AT) begin
				hold_done = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				rsp_stall <= !in_quiet_stretch() && $urandom_range(0, 99) < IDLE_PCT;
			end
		end
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("sorted_insert_table_top_tb: FAIL");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table
		send_request(OP_READ, 32'sh1234_5678, 4'd0);
		send_request(OP_READ, 32'sd0, 4'd15);
		// extremes, ties, reads inside and past the count
		send_request(OP_INSERT, 32'sd0, 4'd15);
		send_request(OP_INSERT, 32'sh7fff_ffff, 4'd0);
		send_request(OP_INSERT, 32'sh8000_0000, 4'd9);
		send_request(OP_INSERT, -32'sd1, 4'd0);
		send_request(OP_INSERT, 32'sd0, 4'd0);
		send_request(OP_INSERT, 32'sd5, 4'd0);
		send_request(OP_INSERT, 32'sd5, 4'd0);
		send_request(OP_READ, 32'sh7fff_ffff, 4'd0);
		send_request(OP_READ, 32'sd0, 4'd2);
		send_request(OP_READ, 32'sd0, 4'd6);
		send_request(OP_READ, 32'sd0, 4'd7);
		send_request(OP_READ, -32'sd1, 4'd15);

		// random mix; the table fills early and stays full
		repeat (RANDOM_REQS)
			send_request(1'($urandom_range(0, 1)), pick_value(),
				INDEX_FIELD_W'($urandom_range(0, 15)));
		req_valid <= 1'b0;

		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("sorted_insert_table_top_tb: PASS");
		else
			$display("sorted_insert_table_top_tb: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/sit_pkg.sv
rtl/sit_ctrl.sv
rtl/sit_dp.sv
rtl/sorted_insert_table_top.sv
dv/sorted_insert_table_checker.sv
dv/sorted_insert_table_top_tb.sv
